/* rtl/core/wsp_pkg.sv */
package wsp_pkg;

	localparam int PAT_MAX   = 16;
	localparam int CFG_BYTES = 16;
	localparam int POS_N     = PAT_MAX + 1;
	localparam int LEN_W     = 5;
	localparam int IDX_W     = $clog2(POS_N);
	localparam int LEN_CAP   = (PAT_MAX < CFG_BYTES) ? PAT_MAX : CFG_BYTES;
	localparam int CFG_W     = 64;
	localparam int CHARS_W   = 8 * CFG_BYTES;
	localparam int QUEUE_D   = 2;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h2E;

	localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
	localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [1:0] REG_LENGTH     = 2'd2;

	typedef struct packed {
		logic [CHARS_W-1:0] chars;
		logic [IDX_W-1:0]   len;
	} wsp_cfg_t;

	typedef struct packed {
		logic [PAT_MAX-1:0] hit;
		logic               no_char;
		logic               end_of_text;
	} wsp_item_t;

	function automatic logic [7:0] pat_byte(input logic [CHARS_W-1:0] chars, input int k);
		logic [7:0] b;
		b = 8'h00;
		if (k < CFG_BYTES) begin
			b = chars[8*k +: 8];
		end
		return b;
	endfunction

	// star closure: a reached star token also reaches the token after it
	function automatic logic [POS_N-1:0] close_set(input logic [POS_N-1:0] raw,
			input logic [PAT_MAX-1:0] star);
		logic [POS_N-1:0] o;
		o = raw;
		for (int k = 0; k < PAT_MAX - 1; k++) begin
			if (o[k] && star[k]) begin
				o[k+2] = 1'b1;
			end
		end
		return o;
	endfunction

endpackage

/* rtl/core/wsp_if.sv */
interface wsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       no_char;
	logic       end_of_text;

	modport source (output valid, output text_byte, output no_char, output end_of_text,
		input ready);
	modport sink (input valid, input text_byte, input no_char, input end_of_text,
		output ready);
endinterface

interface wsp_out_if;
	logic valid;
	logic ready;
	logic matched;
	logic text_done;

	modport source (output valid, output matched, output text_done, input ready);
	modport sink (input valid, input matched, input text_done, output ready);
endinterface

/* rtl/core/wsp_front.sv */
module wsp_front (
	input  wsp_pkg::wsp_cfg_t  cfg,
	wsp_in_if.sink             text_in,
	input  logic               q_full,
	output logic               q_push,
	output wsp_pkg::wsp_item_t q_item
);
	import wsp_pkg::*;

	logic [PAT_MAX-1:0] hit;

	// per-position byte compare against the text byte
	always_comb begin
		for (int k = 0; k < PAT_MAX; k++) begin
			hit[k] = (pat_byte(cfg.chars, k) == text_in.text_byte) ||
				(pat_byte(cfg.chars, k) == ANY_CHAR);
		end
	end

	assign text_in.ready       = !q_full;
	assign q_push              = text_in.valid && !q_full;
	assign q_item.hit          = hit;
	assign q_item.no_char      = text_in.no_char;
	assign q_item.end_of_text  = text_in.end_of_text;

endmodule

/* rtl/core/wsp_queue.sv */
module wsp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wsp_pkg::wsp_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output wsp_pkg::wsp_item_t head
);
	import wsp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_D);

	wsp_item_t              mem_q [QUEUE_D];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [$clog2(QUEUE_D+1)-1:0] count_q;

	assign full      = (count_q == QUEUE_D[$clog2(QUEUE_D+1)-1:0]);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/wsp_back.sv */
module wsp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wsp_pkg::wsp_cfg_t  cfg,
	input  logic               q_not_empty,
	input  wsp_pkg::wsp_item_t q_head,
	output logic               q_pop,
	wsp_out_if.source          result_out
);
	import wsp_pkg::*;

	logic [POS_N-1:0]   act_q;
	logic               out_valid_q;
	logic               matched_q;
	logic               text_done_q;

	logic [PAT_MAX-1:0] star;
	logic [PAT_MAX-1:0] hit_in_len;
	logic [POS_N-1:0]   len_mask;
	logic [POS_N-1:0]   act_masked;
	logic [POS_N-1:0]   cur;
	logic [POS_N-1:0]   nxt;
	logic [POS_N-1:0]   stored;
	logic [POS_N-1:0]   fin;

	always_comb begin
		for (int k = 0; k < PAT_MAX; k++) begin
			star[k]       = ((k + 1) < int'(cfg.len)) &&
				(pat_byte(cfg.chars, k + 1) == STAR_CHAR);
			hit_in_len[k] = q_head.hit[k] && (k < int'(cfg.len));
		end
		for (int k = 0; k < POS_N; k++) begin
			len_mask[k] = (k <= int'(cfg.len));
		end
	end

	assign act_masked = act_q & len_mask;
	assign cur        = close_set(act_masked, star);

	always_comb begin
		nxt = '0;
		for (int k = 0; k < PAT_MAX; k++) begin
			if (cur[k] && hit_in_len[k]) begin
				if (star[k]) begin
					nxt[k] = 1'b1;
				end else begin
					nxt[k+1] = 1'b1;
				end
			end
		end
	end

	assign stored = q_head.no_char ? act_masked : nxt;
	assign fin    = close_set(stored, star);
	assign q_pop  = q_not_empty && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= POS_N'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q <= q_head.end_of_text ? POS_N'(1) : stored;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			matched_q   <= fin[cfg.len];
			text_done_q <= q_head.end_of_text;
		end
	end

	assign result_out.valid     = out_valid_q;
	assign result_out.matched   = matched_q;
	assign result_out.text_done = text_done_q;

endmodule

/* rtl/core/wildcard_star_pattern_matcher_core.sv */
// Whole-text matcher for patterns of literal bytes, '.' (any byte) and "x*" (zero or more
// of x), up to 16 pattern bytes held in three registers. Text streams in one byte per item;
// every item returns one result telling whether the text so far matches the whole pattern,
// and the item with end_of_text set closes the text and restarts the matcher. An item with
// no_char set adds no byte and just reports the current verdict (use it for empty texts).
// One item per clock is sustained while the receiver is ready: the front compares the byte
// against every pattern position, a two-entry queue decouples it from the back, which
// advances the active position set with star closure and holds the result in an output
// register. An accepted item passes through the queue and then the output register before
// its result is presented. Write configuration only while idle.
module wildcard_star_pattern_matcher_core (
	input  logic                       clk,
	input  logic                       arst_n,
	wsp_in_if.sink                     text_in,
	wsp_out_if.source                  result_out,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [wsp_pkg::CFG_W-1:0]  cfg_data
);
	import wsp_pkg::*;

	logic [CFG_W-1:0] chars_low_q;
	logic [CFG_W-1:0] chars_high_q;
	logic [LEN_W-1:0] length_q;
	wsp_cfg_t         cfg;

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	wsp_item_t        q_in;
	wsp_item_t        q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q  <= '0;
			chars_high_q <= '0;
			length_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHARS_LOW:  chars_low_q  <= cfg_data;
				REG_CHARS_HIGH: chars_high_q <= cfg_data;
				REG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// length saturates at the pattern capacity
	always_comb begin
		cfg.chars = CHARS_W'({chars_high_q, chars_low_q});
		if (int'(length_q) > LEN_CAP) begin
			cfg.len = IDX_W'(LEN_CAP);
		end else begin
			cfg.len = IDX_W'(length_q);
		end
	end

	wsp_front u_front (
		.cfg     (cfg),
		.text_in (text_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_in)
	);

	wsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	wsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.result_out  (result_out)
	);

endmodule

/* tb/tb_wildcard_star_pattern_matcher_core.sv */
module tb_wildcard_star_pattern_matcher_core;
	timeunit 1ns;
	timeprecision 1ps;

	import wsp_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int ITEM_TARGET = 450;

	typedef struct {
		bit [7:0] ch;
		bit       no_char;
		bit       eot;
	} text_item_t;

	typedef struct {
		bit matched;
		bit text_done;
	} verdict_t;

	class verdict_board;
		bit [8*CFG_BYTES-1:0] pat_chars;
		bit [LEN_W-1:0]       pat_len_reg;
		bit [POS_N-1:0]       reached;
		verdict_t             expected_verdicts[$];
		int                   errors;

		function new();
			pat_chars = '0;
			pat_len_reg = '0;
			reached = POS_N'(1);
			errors = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_CHARS_LOW: pat_chars[63:0] = value;
				REG_CHARS_HIGH: pat_chars[127:64] = value;
				REG_LENGTH: pat_len_reg = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int used_len();
			int n;
			n = int'(pat_len_reg);
			if (n > CFG_BYTES) n = CFG_BYTES;
			if (n > PAT_MAX) n = PAT_MAX;
			return n;
		endfunction

		function bit [7:0] char_at(int k);
			if (k < CFG_BYTES) return pat_chars[8*k +: 8];
			return 8'h00;
		endfunction

		function bit starred(int k, int n);
			return (k + 1 < n) && (char_at(k + 1) == STAR_CHAR);
		endfunction

		// a reached star token may be skipped, reaching the token after it
		function bit [POS_N-1:0] skip_stars(bit [POS_N-1:0] raw, int n);
			bit [POS_N-1:0] o;
			o = raw;
			for (int k = n + 1; k < POS_N; k++) o[k] = 1'b0;
			for (int k = 0; k < n; k++) begin
				if (o[k] && starred(k, n)) o[k+2] = 1'b1;
			end
			return o;
		endfunction

		function void take_text_item(text_item_t it);
			int             n;
			bit [POS_N-1:0] cur;
			bit [POS_N-1:0] nxt;
			bit [POS_N-1:0] fin;
			bit [7:0]       pc;
			verdict_t       v;
			n = used_len();
			for (int k = n + 1; k < POS_N; k++) reached[k] = 1'b0;
			if (!it.no_char) begin
				cur = skip_stars(reached, n);
				nxt = '0;
				for (int k = 0; k < n; k++) begin
					pc = char_at(k);
					if (cur[k] && (pc == it.ch || pc == ANY_CHAR)) begin
						if (starred(k, n)) nxt[k] = 1'b1;
						else nxt[k+1] = 1'b1;
					end
				end
				reached = nxt;
			end
			fin = skip_stars(reached, n);
			v.matched = fin[n];
			v.text_done = it.eot;
			expected_verdicts.push_back(v);
			if (it.eot) reached = POS_N'(1);
		endfunction

		task report(string what);
			$display("verdict mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_verdict(bit matched, bit text_done);
			verdict_t want;
			if (expected_verdicts.size() == 0) begin
				report("result with no item waiting");
			end else begin
				want = expected_verdicts.pop_front();
				if (matched !== want.matched)
					report($sformatf("matched got %0b want %0b", matched, want.matched));
				if (text_done !== want.text_done)
					report($sformatf("text_done got %0b want %0b", text_done, want.text_done));
			end
		endtask

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	wsp_in_if  text_in_if();
	wsp_out_if result_out_if();

	wildcard_star_pattern_matcher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in_if),
		.result_out(result_out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	verdict_board sb = new();
	text_item_t   stim[$];
	int           burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		text_item_t seen;
		if (arst_n) begin
			if (text_in_if.valid && text_in_if.ready) begin
				seen.ch = text_in_if.text_byte;
				seen.no_char = text_in_if.no_char;
				seen.eot = text_in_if.end_of_text;
				sb.take_text_item(seen);
			end
			if (result_out_if.valid && result_out_if.ready)
				sb.check_verdict(result_out_if.matched, result_out_if.text_done);
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		int span;
		int tick;
		result_out_if.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: result_out_if.ready = 1'b1;
					1: result_out_if.ready = 1'($urandom_range(0, 1));
					2: result_out_if.ready = ($urandom_range(0, 4) == 0);
					3: result_out_if.ready = (tick % 4 == 0);
					default: result_out_if.ready = (tick % 32 >= 24);
				endcase
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_in_if.valid && text_in_if.ready) ||
					(result_out_if.valid && result_out_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_wildcard_star_pattern_matcher_core failed");
		$finish;
	end

	function automatic void add_item(bit [7:0] c, bit nc, bit e);
		text_item_t it;
		it.ch = c;
		it.no_char = nc;
		it.eot = e;
		stim.push_back(it);
	endfunction

	function automatic bit [7:0] pick_letter();
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	function automatic bit [127:0] pack_text(string s);
		bit [127:0] r;
		r = '0;
		for (int i = 0; i < s.len(); i++) r[8*i +: 8] = s[i];
		return r;
	endfunction

	// mostly texts walked along the pattern tokens, some mutated, some noise
	function automatic void add_text(bit close);
		int       n;
		int       k;
		int       kind;
		bit [7:0] c;
		bit [7:0] body[$];
		n = sb.used_len();
		kind = $urandom_range(0, 19);
		if (kind < 14) begin
			k = 0;
			while (k < n) begin
				c = sb.char_at(k);
				if (sb.starred(k, n)) begin
					repeat ($urandom_range(0, 3))
						body.push_back((c == ANY_CHAR) ? pick_letter() : c);
					k += 2;
				end else begin
					body.push_back((c == ANY_CHAR) ? pick_letter() : c);
					k++;
				end
			end
			if (kind >= 10 && body.size() > 0)
				body[$urandom_range(0, body.size() - 1)] = pick_letter();
			if (kind == 13) body.push_back(pick_letter());
		end else if (kind < 17) begin
			repeat ($urandom_range(0, 8)) body.push_back(pick_letter());
		end else begin
			repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
		end
		foreach (body[i]) begin
			if ($urandom_range(0, 9) == 0) add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			add_item(body[i], 1'b0, close && (i == body.size() - 1));
		end
		if (body.size() == 0 && close) add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_pattern(bit [127:0] chars, bit [CFG_W-1:0] len_word);
		write_reg(REG_CHARS_LOW, chars[63:0]);
		write_reg(REG_CHARS_HIGH, chars[127:64]);
		write_reg(REG_LENGTH, len_word);
	endtask

	task automatic random_pattern();
		bit [127:0]     chars;
		bit [CFG_W-1:0] len_word;
		int             style;
		int             target;
		int             n;
		chars = {$urandom, $urandom, $urandom, $urandom};
		style = $urandom_range(0, 9);
		if (style == 0) begin
			n = $urandom_range(0, 31);
		end else begin
			target = (style < 3) ? 16 : $urandom_range(0, 10);
			n = 0;
			while (n < target) begin
				chars[8*n +: 8] = ($urandom_range(0, 4) == 0) ? ANY_CHAR : pick_letter();
				n++;
				if (n < target && $urandom_range(0, 2) == 0) begin
					chars[8*n +: 8] = STAR_CHAR;
					n++;
				end
			end
			if (style == 1) chars[8*$urandom_range(0, 15) +: 8] = STAR_CHAR;
			if (style == 2 && $urandom_range(0, 1) == 1) n = $urandom_range(17, 31);
		end
		len_word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
		len_word[LEN_W-1:0] = n[LEN_W-1:0];
		load_pattern(chars, len_word);
	endtask

	// called and returns at a falling edge
	task automatic send_all();
		text_item_t it;
		int         gap;
		while (stim.size() > 0) begin
			it = stim.pop_front();
			if ($urandom_range(0, 60) == 0) begin
				text_in_if.valid = 1'b0;
				while (sb.pending() != 0) @(negedge clk);
			end
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					text_in_if.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			text_in_if.valid = 1'b1;
			text_in_if.text_byte = it.ch;
			text_in_if.no_char = it.no_char;
			text_in_if.end_of_text = it.eot;
			do @(posedge clk); while (!text_in_if.ready);
			burst_left--;
			@(negedge clk);
		end
		text_in_if.valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int sent;
		int texts;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CHARS_LOW;
		cfg_data = '0;
		text_in_if.valid = 1'b0;
		text_in_if.text_byte = 8'h00;
		text_in_if.no_char = 1'b0;
		text_in_if.end_of_text = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pattern straight after reset
		add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		add_item("a", 1'b0, 1'b1);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hFF, 1'b1, 1'b1);
		send_all();
		drain();

		// star, any byte and literal tokens; text left open at the end
		load_pattern(pack_text("a*b.c*"), CFG_W'(6));
		add_item("b", 1'b0, 1'b0);
		add_item("x", 1'b0, 1'b1);
		add_item("a", 1'b0, 1'b0);
		add_item("b", 1'b0, 1'b0);
		add_item(8'hFF, 1'b0, 1'b0);
		add_item("c", 1'b0, 1'b1);
		add_item("b", 1'b0, 1'b0);
		add_item(ANY_CHAR, 1'b0, 1'b0);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(STAR_CHAR, 1'b0, 1'b1);
		add_item(8'h00, 1'b1, 1'b1);
		add_item("b", 1'b0, 1'b0);
		send_all();
		drain();

		// length above the pattern size saturates
		load_pattern(pack_text("x*x*x*x*x*x*x*x*"), '1);
		add_item("x", 1'b0, 1'b0);
		add_item("x", 1'b0, 1'b1);
		add_item("y", 1'b0, 1'b1);
		add_item("x", 1'b0, 1'b0);
		send_all();
		drain();

		// leading star and doubled star, pattern shrunk under an open text
		load_pattern(pack_text("*a**"), CFG_W'(4));
		add_item(STAR_CHAR, 1'b0, 1'b1);
		add_item(STAR_CHAR, 1'b0, 1'b0);
		add_item("a", 1'b0, 1'b0);
		add_item(STAR_CHAR, 1'b0, 1'b1);
		add_item(STAR_CHAR, 1'b0, 1'b0);
		add_item(STAR_CHAR, 1'b0, 1'b1);
		send_all();
		drain();

		sent = 0;
		while (sent < ITEM_TARGET) begin
			random_pattern();
			texts = $urandom_range(2, 6);
			for (int i = 0; i < texts; i++)
				add_text((i < texts - 1) || ($urandom_range(0, 3) != 0));
			sent += stim.size();
			send_all();
			drain();
		end

		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_wildcard_star_pattern_matcher_core passed");
		else
			$display("tb_wildcard_star_pattern_matcher_core failed");
		$finish;
	end

endmodule
